/* src/soa_pkg.sv */
`default_nettype none

package soa_pkg;

  localparam int SLAB_SLOTS  = 16;
  localparam int MAX_OBJECTS = 64;
  localparam int SLOT_W      = $clog2(SLAB_SLOTS);
  localparam int OBJ_W       = $clog2(MAX_OBJECTS);
  localparam int LINK_W      = SLOT_W + 1;
  localparam int CNT_W       = OBJ_W + 1;
  localparam int FREE_W      = 11;
  localparam int REL_W       = 5;
  localparam int NCFG_W      = 7;
  localparam int CFG_IDX_W   = 1;

  // A link value with the top bit set is the null marker.
  localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(SLAB_SLOTS);
  // A chain entry with the top bit set ends the free-object chain.
  localparam logic [CNT_W-1:0]  CHAIN_END = '1;
  localparam logic [FREE_W-1:0] FREE_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECTS_PER_SLAB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_LIMIT       = 1'd1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SLOT    = 2'd1,
    STAT_BAD_HANDLE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLAB_UNUSED  = 2'd0,
    SLAB_EMPTY   = 2'd1,
    SLAB_PARTIAL = 2'd2,
    SLAB_FULL    = 2'd3
  } slab_st_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SELECT,
    OP_FILL,
    OP_GROW,
    OP_GRANT_RD,
    OP_GRANT,
    OP_UNLINK,
    OP_SETTLE,
    OP_FREE,
    OP_PUSH,
    OP_RELEASE,
    OP_ERR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    push_empty;
    status_t err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic list_avail;
    logic unused_avail;
    logic free_ok;
    logic fill_last;
    logic sel_count_zero;
    logic sel_full;
    logic over_limit;
    logic release_go;
    logic out_room;
  } dp_stat_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DECODE,
    CS_FILL,
    CS_GROW,
    CS_GRANT_RD,
    CS_GRANT_UPD,
    CS_GRANT_UNLINK,
    CS_GRANT_LINK,
    CS_FREE_NEXT,
    CS_FREE_UNLINK,
    CS_FREE_PUSH,
    CS_RELEASE,
    CS_EMIT
  } ctl_state_t;

endpackage

`default_nettype wire

/* src/slab_object_allocator_top.sv */
`default_nettype none

// Slab object allocator for a single object size. Each request is either an
// allocate (in_tuser = 0) or a free of the handle in in_tdata (in_tuser = 1),
// and every request gives exactly one result on the out_ channel: a status,
// the granted handle for a successful allocate, the free-object total after
// the request and the number of empty slabs given back by it. Allocates take
// the head slab of the partial list, then of the empty list, then claim the
// lowest unused slab slot and build its free chain. Requests are handled one
// at a time by a controller over a shared datapath whose free-object chains
// sit in a single-port-write, registered-read memory of 16 x 64 entries.
// Growing a new slab first writes its chain of clamped objects_per_slab
// entries, one entry per cycle through the memory write port. A free that
// empties its slab moves the slab to the empty list; when the free-object
// total then exceeds the limit, a release walk gives back empty slabs one
// at a time. A new request is accepted as soon as the previous result sits
// in the output register, even if it has not yet been taken. The chain
// memory needs no clearing after reset. Configuration is written through
// cfg_; the user must do so only while no request is in flight, which the
// block itself does not enforce.
module slab_object_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // Bits 3:0 slab_number, bits 9:4 object_index, upper bits zero.
  input  wire logic [15:0]                   in_tdata,
  // Bit 0 kind: 0 allocate, 1 free.
  input  wire logic [0:0]                    in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // Bits 1:0 status, 5:2 granted_slab, 11:6 granted_index,
  // 22:12 free_count, 27:23 slabs_released, upper bits zero.
  output logic [31:0]                        out_tdata,
  // Configuration: index 0 objects_per_slab, index 1 free_object_limit.
  input  wire logic                          cfg_we,
  input  wire logic [soa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [soa_pkg::FREE_W-1:0]    cfg_wdata
);

  soa_pkg::dp_cmd_t  cmd;
  soa_pkg::dp_stat_t st;

  // The controller sequences each request; the datapath holds all slab state.
  soa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  soa_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

endmodule

`default_nettype wire

/* src/soa_ctrl.sv */
`default_nettype none

module soa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire soa_pkg::dp_stat_t st,
  output soa_pkg::dp_cmd_t       cmd
);

  soa_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= soa_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      soa_pkg::CS_IDLE: begin
        if (in_tvalid) state_nxt = soa_pkg::CS_DECODE;
      end
      soa_pkg::CS_DECODE: begin
        if (!st.req_free) begin
          if (st.list_avail) state_nxt = soa_pkg::CS_GRANT_RD;
          else if (st.unused_avail) state_nxt = soa_pkg::CS_FILL;
          else state_nxt = soa_pkg::CS_EMIT;
        end else if (st.free_ok) begin
          state_nxt = soa_pkg::CS_FREE_NEXT;
        end else begin
          state_nxt = soa_pkg::CS_EMIT;
        end
      end
      soa_pkg::CS_FILL: begin
        if (st.fill_last) state_nxt = soa_pkg::CS_GROW;
      end
      soa_pkg::CS_GROW:         state_nxt = soa_pkg::CS_GRANT_RD;
      soa_pkg::CS_GRANT_RD:     state_nxt = soa_pkg::CS_GRANT_UPD;
      soa_pkg::CS_GRANT_UPD:    state_nxt = soa_pkg::CS_GRANT_UNLINK;
      soa_pkg::CS_GRANT_UNLINK: state_nxt = soa_pkg::CS_GRANT_LINK;
      soa_pkg::CS_GRANT_LINK:   state_nxt = soa_pkg::CS_EMIT;
      soa_pkg::CS_FREE_NEXT: begin
        if (st.sel_count_zero) state_nxt = soa_pkg::CS_FREE_UNLINK;
        else state_nxt = soa_pkg::CS_EMIT;
      end
      soa_pkg::CS_FREE_UNLINK:  state_nxt = soa_pkg::CS_FREE_PUSH;
      soa_pkg::CS_FREE_PUSH: begin
        if (st.over_limit) state_nxt = soa_pkg::CS_RELEASE;
        else state_nxt = soa_pkg::CS_EMIT;
      end
      soa_pkg::CS_RELEASE: begin
        if (!st.release_go) state_nxt = soa_pkg::CS_EMIT;
      end
      soa_pkg::CS_EMIT: begin
        if (st.out_room) state_nxt = soa_pkg::CS_IDLE;
      end
      default: state_nxt = soa_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    cmd.op         = soa_pkg::OP_NONE;
    cmd.push_empty = 1'b0;
    cmd.err_code   = soa_pkg::STAT_OK;
    case (state_r)
      soa_pkg::CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = soa_pkg::OP_LOAD;
      end
      soa_pkg::CS_DECODE: begin
        if (!st.req_free) begin
          if (st.list_avail || st.unused_avail) begin
            cmd.op = soa_pkg::OP_SELECT;
          end else begin
            cmd.op       = soa_pkg::OP_ERR;
            cmd.err_code = soa_pkg::STAT_NO_SLOT;
          end
        end else if (st.free_ok) begin
          cmd.op = soa_pkg::OP_FREE;
        end else begin
          cmd.op       = soa_pkg::OP_ERR;
          cmd.err_code = soa_pkg::STAT_BAD_HANDLE;
        end
      end
      soa_pkg::CS_FILL:         cmd.op = soa_pkg::OP_FILL;
      soa_pkg::CS_GROW:         cmd.op = soa_pkg::OP_GROW;
      soa_pkg::CS_GRANT_RD:     cmd.op = soa_pkg::OP_GRANT_RD;
      soa_pkg::CS_GRANT_UPD:    cmd.op = soa_pkg::OP_GRANT;
      soa_pkg::CS_GRANT_UNLINK: cmd.op = soa_pkg::OP_UNLINK;
      soa_pkg::CS_GRANT_LINK:   cmd.op = soa_pkg::OP_SETTLE;
      soa_pkg::CS_FREE_NEXT: begin
        if (!st.sel_count_zero && st.sel_full) cmd.op = soa_pkg::OP_PUSH;
      end
      soa_pkg::CS_FREE_UNLINK:  cmd.op = soa_pkg::OP_UNLINK;
      soa_pkg::CS_FREE_PUSH: begin
        cmd.op         = soa_pkg::OP_PUSH;
        cmd.push_empty = 1'b1;
      end
      soa_pkg::CS_RELEASE: begin
        if (st.release_go) cmd.op = soa_pkg::OP_RELEASE;
      end
      soa_pkg::CS_EMIT: begin
        if (st.out_room) cmd.op = soa_pkg::OP_EMIT;
      end
      default: cmd.op = soa_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* src/soa_datapath.sv */
`default_nettype none

module soa_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire soa_pkg::dp_cmd_t              cmd,
  output soa_pkg::dp_stat_t                  st,
  input  wire logic [15:0]                   in_tdata,
  input  wire logic [0:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [31:0]                        out_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [soa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [soa_pkg::FREE_W-1:0]    cfg_wdata
);

  localparam int SW = soa_pkg::SLOT_W;
  localparam int OW = soa_pkg::OBJ_W;
  localparam int LW = soa_pkg::LINK_W;
  localparam int CW = soa_pkg::CNT_W;
  localparam int FW = soa_pkg::FREE_W;
  localparam int RW = soa_pkg::REL_W;
  localparam int NS = soa_pkg::SLAB_SLOTS;

  // Free-object chain links, one row of MAX_OBJECTS entries per slab slot.
  logic [CW-1:0] chain_mem [soa_pkg::SLAB_SLOTS*soa_pkg::MAX_OBJECTS];
  logic [CW-1:0] rd_data_r;
  logic          mem_we;
  logic [SW+OW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;

  logic [CW-1:0] head_r [NS];
  logic [CW-1:0] head_nxt [NS];
  logic [CW-1:0] cnt_r [NS];
  logic [CW-1:0] cnt_nxt [NS];
  soa_pkg::slab_st_t sts_r [NS];
  soa_pkg::slab_st_t sts_nxt [NS];
  logic [LW-1:0] lnext_r [NS];
  logic [LW-1:0] lnext_nxt [NS];
  logic [LW-1:0] lprev_r [NS];
  logic [LW-1:0] lprev_nxt [NS];
  logic [LW-1:0] phead_r, phead_nxt;
  logic [LW-1:0] ehead_r, ehead_nxt;
  logic [FW-1:0] tfree_r, tfree_nxt;

  logic [soa_pkg::NCFG_W-1:0] ncfg_r;
  logic [FW-1:0]              limit_r;

  logic          req_kind_r;
  logic [SW-1:0] req_slab_r;
  logic [OW-1:0] req_idx_r;
  logic [SW-1:0] sel_r, sel_nxt;
  logic [OW-1:0] fill_k_r, fill_k_nxt;
  logic          end_r, end_nxt;

  soa_pkg::status_t res_status_r, res_status_nxt;
  logic [OW-1:0]    res_idx_r, res_idx_nxt;
  logic [RW-1:0]    rel_r, rel_nxt;

  logic          out_valid_r;
  logic [31:0]   out_data_r;

  logic [CW-1:0] n_eff;
  logic [OW-1:0] n_last;
  logic          unused_found;
  logic [SW-1:0] unused_slot;
  logic [SW-1:0] alloc_slot;
  logic [SW-1:0] tgt;
  logic          do_unlink, do_push, push_empty;
  logic [LW-1:0] ul_prev, ul_next, push_head;
  logic [FW:0]   free_sum;
  logic [CW-1:0] grant_head, grant_next;
  logic [FW-1:0] n_wide;

  // Objects per slab, clamped to the legal range.
  always_comb begin
    if (ncfg_r < soa_pkg::NCFG_W'(2)) n_eff = CW'(2);
    else if (ncfg_r > soa_pkg::NCFG_W'(soa_pkg::MAX_OBJECTS))
      n_eff = CW'(soa_pkg::MAX_OBJECTS);
    else n_eff = CW'(ncfg_r);
  end
  assign n_last = OW'(n_eff - CW'(1));
  assign n_wide = FW'(n_eff);

  always_comb begin
    unused_found = 1'b0;
    unused_slot  = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (sts_r[i] == soa_pkg::SLAB_UNUSED) begin
        unused_found = 1'b1;
        unused_slot  = SW'(i);
      end
    end
  end

  always_comb begin
    if (!phead_r[SW]) alloc_slot = phead_r[SW-1:0];
    else if (!ehead_r[SW]) alloc_slot = ehead_r[SW-1:0];
    else alloc_slot = unused_slot;
  end

  assign grant_head = head_r[sel_r];
  assign grant_next = grant_head[CW-1] ? soa_pkg::CHAIN_END : rd_data_r;

  always_comb begin
    st.req_free       = req_kind_r;
    st.list_avail     = !phead_r[SW] || !ehead_r[SW];
    st.unused_avail   = unused_found;
    st.free_ok        = (sts_r[req_slab_r] != soa_pkg::SLAB_UNUSED) &&
                        (CW'(req_idx_r) < n_eff) && (cnt_r[req_slab_r] != '0);
    st.fill_last      = (fill_k_r == n_last);
    st.sel_count_zero = (cnt_r[sel_r] == '0);
    st.sel_full       = (sts_r[sel_r] == soa_pkg::SLAB_FULL);
    st.over_limit     = (tfree_r > limit_r);
    st.release_go     = !ehead_r[SW] && (tfree_r >= limit_r);
    st.out_room       = !out_valid_r || out_tready;
  end

  always_comb begin
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    sts_nxt        = sts_r;
    lnext_nxt      = lnext_r;
    lprev_nxt      = lprev_r;
    phead_nxt      = phead_r;
    ehead_nxt      = ehead_r;
    tfree_nxt      = tfree_r;
    sel_nxt        = sel_r;
    fill_k_nxt     = fill_k_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    rel_nxt        = rel_r;
    mem_we         = 1'b0;
    mem_waddr      = {sel_r, fill_k_r};
    mem_wdata      = CW'(fill_k_r) + CW'(1);
    do_unlink      = 1'b0;
    do_push        = 1'b0;
    push_empty     = 1'b0;
    free_sum       = '0;
    tgt            = sel_r;
    ul_prev        = '0;
    ul_next        = '0;
    push_head      = '0;

    case (cmd.op)
      soa_pkg::OP_LOAD: begin
        res_status_nxt = soa_pkg::STAT_OK;
        res_idx_nxt    = '0;
        rel_nxt        = '0;
        sel_nxt        = '0;
      end
      soa_pkg::OP_SELECT: begin
        sel_nxt    = alloc_slot;
        fill_k_nxt = '0;
      end
      soa_pkg::OP_FILL: begin
        mem_we = 1'b1;
        if (fill_k_r == n_last) mem_wdata = soa_pkg::CHAIN_END;
        fill_k_nxt = fill_k_r + OW'(1);
      end
      soa_pkg::OP_GROW: begin
        head_nxt[sel_r] = '0;
        cnt_nxt[sel_r]  = '0;
        do_push         = 1'b1;
        push_empty      = 1'b1;
        free_sum        = {1'b0, tfree_r} + {1'b0, n_wide};
        tfree_nxt       = free_sum[FW] ? soa_pkg::FREE_MAX : free_sum[FW-1:0];
      end
      soa_pkg::OP_GRANT: begin
        head_nxt[sel_r] = grant_next;
        if (cnt_r[sel_r] != '1) cnt_nxt[sel_r] = cnt_r[sel_r] + CW'(1);
        tfree_nxt   = (tfree_r != '0) ? tfree_r - FW'(1) : '0;
        res_idx_nxt = grant_head[CW-1] ? '0 : grant_head[OW-1:0];
        end_nxt     = grant_next[CW-1];
      end
      soa_pkg::OP_UNLINK: begin
        do_unlink = 1'b1;
      end
      soa_pkg::OP_SETTLE: begin
        if (end_r) sts_nxt[sel_r] = soa_pkg::SLAB_FULL;
        else do_push = 1'b1;
      end
      soa_pkg::OP_FREE: begin
        mem_we     = 1'b1;
        mem_waddr  = {req_slab_r, req_idx_r};
        mem_wdata  = head_r[req_slab_r];
        head_nxt[req_slab_r] = CW'(req_idx_r);
        cnt_nxt[req_slab_r]  = cnt_r[req_slab_r] - CW'(1);
        free_sum   = {1'b0, tfree_r} + (FW+1)'(1);
        tfree_nxt  = free_sum[FW] ? soa_pkg::FREE_MAX : free_sum[FW-1:0];
        sel_nxt    = req_slab_r;
      end
      soa_pkg::OP_PUSH: begin
        do_push    = 1'b1;
        push_empty = cmd.push_empty;
      end
      soa_pkg::OP_RELEASE: begin
        tgt          = ehead_r[SW-1:0];
        do_unlink    = 1'b1;
        sts_nxt[tgt] = soa_pkg::SLAB_UNUSED;
        cnt_nxt[tgt] = '0;
        tfree_nxt    = (tfree_r > n_wide) ? tfree_r - n_wide : '0;
        rel_nxt      = rel_r + RW'(1);
      end
      soa_pkg::OP_ERR: begin
        res_status_nxt = cmd.err_code;
      end
      default: begin
      end
    endcase

    // Take the target slab out of whichever list holds it.
    if (do_unlink && (sts_r[tgt] == soa_pkg::SLAB_EMPTY ||
                      sts_r[tgt] == soa_pkg::SLAB_PARTIAL)) begin
      ul_prev = lprev_r[tgt];
      ul_next = lnext_r[tgt];
      if (!ul_prev[SW]) lnext_nxt[ul_prev[SW-1:0]] = ul_next;
      else if (sts_r[tgt] == soa_pkg::SLAB_EMPTY) ehead_nxt = ul_next;
      else phead_nxt = ul_next;
      if (!ul_next[SW]) lprev_nxt[ul_next[SW-1:0]] = ul_prev;
      lnext_nxt[tgt] = soa_pkg::LINK_NIL;
      lprev_nxt[tgt] = soa_pkg::LINK_NIL;
    end

    // Put the selected slab at the head of the empty or partial list.
    if (do_push) begin
      push_head = push_empty ? ehead_r : phead_r;
      lprev_nxt[sel_r] = soa_pkg::LINK_NIL;
      lnext_nxt[sel_r] = push_head;
      if (!push_head[SW]) lprev_nxt[push_head[SW-1:0]] = LW'(sel_r);
      if (push_empty) begin
        ehead_nxt      = LW'(sel_r);
        sts_nxt[sel_r] = soa_pkg::SLAB_EMPTY;
      end else begin
        phead_nxt      = LW'(sel_r);
        sts_nxt[sel_r] = soa_pkg::SLAB_PARTIAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) chain_mem[mem_waddr] <= mem_wdata;
    if (cmd.op == soa_pkg::OP_GRANT_RD) begin
      rd_data_r <= chain_mem[{sel_r, grant_head[OW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        cnt_r[i]   <= '0;
        sts_r[i]   <= soa_pkg::SLAB_UNUSED;
        lnext_r[i] <= soa_pkg::LINK_NIL;
        lprev_r[i] <= soa_pkg::LINK_NIL;
      end
      phead_r     <= soa_pkg::LINK_NIL;
      ehead_r     <= soa_pkg::LINK_NIL;
      tfree_r     <= '0;
      ncfg_r      <= soa_pkg::NCFG_W'(soa_pkg::MAX_OBJECTS);
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      sts_r   <= sts_nxt;
      lnext_r <= lnext_nxt;
      lprev_r <= lprev_nxt;
      phead_r <= phead_nxt;
      ehead_r <= ehead_nxt;
      tfree_r <= tfree_nxt;
      if (cfg_we) begin
        case (cfg_index)
          soa_pkg::REG_OBJECTS_PER_SLAB: ncfg_r  <= cfg_wdata[soa_pkg::NCFG_W-1:0];
          soa_pkg::REG_FREE_LIMIT:       limit_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.op == soa_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    sel_r        <= sel_nxt;
    fill_k_r     <= fill_k_nxt;
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    rel_r        <= rel_nxt;
    if (cmd.op == soa_pkg::OP_LOAD) begin
      req_kind_r <= in_tuser[0];
      req_slab_r <= in_tdata[SW-1:0];
      req_idx_r  <= in_tdata[SW+OW-1:SW];
    end
    if (cmd.op == soa_pkg::OP_EMIT) begin
      out_data_r <= {4'd0, rel_r, tfree_r,
                     (res_status_r == soa_pkg::STAT_OK && !req_kind_r) ? res_idx_r : OW'(0),
                     (res_status_r == soa_pkg::STAT_OK && !req_kind_r) ? sel_r : SW'(0),
                     res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* dv/slab_object_allocator_top_tb.sv */
module slab_object_allocator_top_tb;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int SETTLE_WAIT  = 120;  // longer than a grow plus a full release walk
  localparam int HOLD_STRETCH = 400;
  localparam int NUM_DIRECTED = 20;
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam int END_OF_CHAIN = 65535;
  localparam int NO_SLAB      = soa_pkg::SLAB_SLOTS;
  localparam int NSLOTS       = soa_pkg::SLAB_SLOTS;
  localparam int NOBJ         = soa_pkg::MAX_OBJECTS;

  // Fields of one result.
  typedef struct packed {
    soa_pkg::status_t status;
    logic [3:0]       granted_slab;
    logic [5:0]       granted_index;
    logic [10:0]      free_count;
    logic [4:0]       slabs_released;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_CFG} row_op_t;

  // One line of the directed table. For a configuration row, slab_field holds
  // the register index and data_field the value written.
  typedef struct {
    row_op_t       op;
    int            slab_field;
    int            data_field;
    bit            typed;
    alloc_result_t known;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic                          cfg_we;
  logic [soa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [soa_pkg::FREE_W-1:0]    cfg_wdata;

  slab_object_allocator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the allocator's state. Links use NO_SLAB as the null marker and
  // END_OF_CHAIN closes a slab's free-object chain.
  int                object_link [NSLOTS*NOBJ];
  int                chain_top [NSLOTS];
  int                objects_in_use [NSLOTS];
  soa_pkg::slab_st_t slab_state [NSLOTS];
  int                next_slab [NSLOTS];
  int                prev_slab [NSLOTS];
  int                partial_top;
  int                empty_top;
  int                free_total;
  int                shadow_per_slab;
  int                shadow_limit;

  alloc_result_t pending_results[$];
  int            live_handles[$];  // slab * NOBJ + index of granted objects
  int            failures;
  int            cycle_count;
  int            recv_stall_pct;
  int            hold_cycles;
  stim_row_t     directed_rows [NUM_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The register holds up to 127, but the block clamps the slab size to the
  // range it can carve.
  function automatic int eff_objects();
    if (shadow_per_slab < 2) return 2;
    if (shadow_per_slab > NOBJ) return NOBJ;
    return shadow_per_slab;
  endfunction

  function automatic void take_off_list(int s);
    int p;
    int nx;
    p = prev_slab[s];
    nx = next_slab[s];
    if (slab_state[s] != soa_pkg::SLAB_EMPTY && slab_state[s] != soa_pkg::SLAB_PARTIAL) return;
    if (p < NO_SLAB) next_slab[p] = nx;
    else if (slab_state[s] == soa_pkg::SLAB_EMPTY) empty_top = nx;
    else partial_top = nx;
    if (nx < NO_SLAB) prev_slab[nx] = p;
    next_slab[s] = NO_SLAB;
    prev_slab[s] = NO_SLAB;
  endfunction

  function automatic void put_on_list(int s, soa_pkg::slab_st_t st);
    int top;
    top = (st == soa_pkg::SLAB_EMPTY) ? empty_top : partial_top;
    prev_slab[s] = NO_SLAB;
    next_slab[s] = top;
    if (top < NO_SLAB) prev_slab[top] = s;
    if (st == soa_pkg::SLAB_EMPTY) empty_top = s;
    else partial_top = s;
    slab_state[s] = st;
  endfunction

  function automatic void free_total_add(int k);
    free_total = (free_total + k > 2047) ? 2047 : free_total + k;
  endfunction

  function automatic void free_total_sub(int k);
    free_total = (free_total > k) ? free_total - k : 0;
  endfunction

  function automatic void reset_shadow();
    foreach (object_link[i]) object_link[i] = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      chain_top[i] = 0;
      objects_in_use[i] = 0;
      slab_state[i] = soa_pkg::SLAB_UNUSED;
      next_slab[i] = NO_SLAB;
      prev_slab[i] = NO_SLAB;
    end
    partial_top = NO_SLAB;
    empty_top = NO_SLAB;
    free_total = 0;
    shadow_per_slab = 64;
    shadow_limit = 0;
  endfunction

  // Applies one request to the shadow state and returns the result it causes.
  function automatic alloc_result_t allocator_step(logic kind, int slab_no, int obj);
    alloc_result_t r;
    int n;
    int s;
    int idx;
    int nxt;
    int victim;
    n = eff_objects();
    r = '0;
    r.status = soa_pkg::STAT_OK;
    if (kind == KIND_ALLOC) begin
      s = NO_SLAB;
      if (partial_top < NO_SLAB) s = partial_top;
      else if (empty_top < NO_SLAB) s = empty_top;
      else begin
        for (int i = 0; i < NSLOTS; i++)
          if (s == NO_SLAB && slab_state[i] == soa_pkg::SLAB_UNUSED) s = i;
        if (s < NO_SLAB) begin
          // A newly claimed slab chains its objects in order.
          for (int k = 0; k + 1 < n; k++) object_link[s*NOBJ + k] = k + 1;
          object_link[s*NOBJ + n - 1] = END_OF_CHAIN;
          chain_top[s] = 0;
          objects_in_use[s] = 0;
          put_on_list(s, soa_pkg::SLAB_EMPTY);
          free_total_add(n);
        end
      end
      if (s < NO_SLAB) begin
        idx = chain_top[s];
        if (idx >= NOBJ) begin
          idx = 0;
          nxt = END_OF_CHAIN;
        end else begin
          nxt = object_link[s*NOBJ + idx];
        end
        chain_top[s] = nxt;
        if (objects_in_use[s] < 65535) objects_in_use[s]++;
        free_total_sub(1);
        take_off_list(s);
        if (nxt == END_OF_CHAIN) slab_state[s] = soa_pkg::SLAB_FULL;
        else put_on_list(s, soa_pkg::SLAB_PARTIAL);
        r.granted_slab = s[3:0];
        r.granted_index = idx[5:0];
      end else begin
        r.status = soa_pkg::STAT_NO_SLOT;
      end
    end else begin
      if (slab_state[slab_no] == soa_pkg::SLAB_UNUSED || obj >= n ||
          objects_in_use[slab_no] == 0) begin
        r.status = soa_pkg::STAT_BAD_HANDLE;
      end else begin
        object_link[slab_no*NOBJ + obj] = chain_top[slab_no];
        chain_top[slab_no] = obj;
        objects_in_use[slab_no]--;
        free_total_add(1);
        if (objects_in_use[slab_no] == 0) begin
          take_off_list(slab_no);
          put_on_list(slab_no, soa_pkg::SLAB_EMPTY);
          if (free_total > shadow_limit) begin
            while (empty_top < NO_SLAB && free_total >= shadow_limit) begin
              victim = empty_top;
              take_off_list(victim);
              slab_state[victim] = soa_pkg::SLAB_UNUSED;
              objects_in_use[victim] = 0;
              free_total_sub(n);
              r.slabs_released++;
            end
          end
        end else if (slab_state[slab_no] == soa_pkg::SLAB_FULL) begin
          put_on_list(slab_no, soa_pkg::SLAB_PARTIAL);
        end
      end
    end
    r.free_count = free_total[10:0];
    return r;
  endfunction

  // The receiver stalls at the current rate, or all the time during a hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each taken result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status         = soa_pkg::status_t'(out_tdata[1:0]);
      got.granted_slab   = out_tdata[5:2];
      got.granted_index  = out_tdata[11:6];
      got.free_count     = out_tdata[22:12];
      got.slabs_released = out_tdata[27:23];
      if (pending_results.size() == 0) begin
        $error("result with no outstanding request: %h", out_tdata);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
        if (got.granted_slab != want.granted_slab) begin
          $error("granted_slab: expected %0d, got %0d", want.granted_slab, got.granted_slab);
          failures++;
        end
        if (got.granted_index != want.granted_index) begin
          $error("granted_index: expected %0d, got %0d", want.granted_index,
                 got.granted_index);
          failures++;
        end
        if (got.free_count != want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
          failures++;
        end
        if (got.slabs_released != want.slabs_released) begin
          $error("slabs_released: expected %0d, got %0d", want.slabs_released,
                 got.slabs_released);
          failures++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one request, waits for it to be taken, then records its expected
  // result: the typed one where given, otherwise the shadow's prediction.
  task automatic submit(logic kind, int slab_no, int obj, bit typed, alloc_result_t known);
    alloc_result_t predicted;
    int h;
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'd0, obj[5:0], slab_no[3:0]};
    do @(posedge clk); while (!in_tready);
    predicted = allocator_step(kind, slab_no, obj);
    pending_results.push_back(typed ? known : predicted);
    // Keep the list of handles that are still out in step with the shadow.
    if (predicted.status == soa_pkg::STAT_OK && kind == KIND_ALLOC) begin
      live_handles.push_back(predicted.granted_slab * NOBJ + predicted.granted_index);
    end else if (predicted.status == soa_pkg::STAT_OK) begin
      h = slab_no * NOBJ + obj;
      foreach (live_handles[i]) begin
        if (live_handles[i] == h) begin
          live_handles.delete(i);
          break;
        end
      end
    end
    for (int i = live_handles.size() - 1; i >= 0; i--)
      if (slab_state[live_handles[i] / NOBJ] == soa_pkg::SLAB_UNUSED) live_handles.delete(i);
  endtask

  // Waits for every result and for the block to finish any release walk.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Registers are written only once the block has gone idle.
  task automatic write_reg(logic [soa_pkg::CFG_IDX_W-1:0] idx, int value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[soa_pkg::FREE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == soa_pkg::REG_OBJECTS_PER_SLAB) shadow_per_slab = value & 8'h7f;
    else shadow_limit = value & 12'h7ff;
  endtask

  // A phase of random requests: mostly allocates and frees of live handles,
  // with some frees of arbitrary handles to reach the error paths.
  task automatic random_phase(int count, int alloc_pct, int send_idle_pct);
    int pick;
    int h;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        submit(KIND_ALLOC, $urandom_range(15), $urandom_range(63), 1'b0, '0);
      end else if (pick < 92 && live_handles.size() != 0) begin
        h = live_handles[$urandom_range(live_handles.size() - 1)];
        submit(KIND_FREE, h / NOBJ, h % NOBJ, 1'b0, '0);
      end else begin
        submit(KIND_FREE, $urandom_range(15), $urandom_range(63), 1'b0, '0);
      end
    end
  endtask

  initial begin
    // Directed table. Known results are typed in where they follow directly
    // from the reset state: the first grants, bad handles and the release of
    // an emptied slab with a zero limit.
    directed_rows = '{
      '{ROW_FREE,  0,  0, 1'b1, '{soa_pkg::STAT_BAD_HANDLE, 4'd0, 6'd0, 11'd0,  5'd0}},
      '{ROW_ALLOC, 0,  0, 1'b1, '{soa_pkg::STAT_OK,         4'd0, 6'd0, 11'd63, 5'd0}},
      '{ROW_ALLOC, 0,  0, 1'b1, '{soa_pkg::STAT_OK,         4'd0, 6'd1, 11'd62, 5'd0}},
      '{ROW_FREE,  15, 63, 1'b1, '{soa_pkg::STAT_BAD_HANDLE, 4'd0, 6'd0, 11'd62, 5'd0}},
      '{ROW_FREE,  0,  1, 1'b1, '{soa_pkg::STAT_OK,         4'd0, 6'd0, 11'd63, 5'd0}},
      '{ROW_FREE,  0,  0, 1'b1, '{soa_pkg::STAT_OK,         4'd0, 6'd0, 11'd0,  5'd1}},
      '{ROW_ALLOC, 0,  0, 1'b0, '0},
      '{ROW_ALLOC, 0,  0, 1'b0, '0},
      '{ROW_ALLOC, 0,  0, 1'b0, '0},
      '{ROW_FREE,  0,  1, 1'b0, '0},
      // The same object again: a double free in a partial slab goes through.
      '{ROW_FREE,  0,  1, 1'b0, '0},
      '{ROW_FREE,  0,  0, 1'b0, '0},
      '{ROW_CFG,   soa_pkg::REG_OBJECTS_PER_SLAB, 2, 1'b0, '0},
      '{ROW_ALLOC, 0,  0, 1'b0, '0},
      '{ROW_ALLOC, 0,  0, 1'b0, '0},
      // Index beyond the current slab size.
      '{ROW_FREE,  0,  2, 1'b1, '{soa_pkg::STAT_BAD_HANDLE, 4'd0, 6'd0, 11'd0,  5'd0}},
      // A free into a full slab moves it to the partial list.
      '{ROW_FREE,  0,  1, 1'b0, '0},
      '{ROW_ALLOC, 0,  0, 1'b0, '0},
      '{ROW_FREE,  9,  5, 1'b1, '{soa_pkg::STAT_BAD_HANDLE, 4'd0, 6'd0, 11'd0,  5'd0}},
      '{ROW_CFG,   soa_pkg::REG_FREE_LIMIT, 3, 1'b0, '0}
    };

    failures = 0;
    cycle_count = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_CFG: begin
          write_reg(soa_pkg::CFG_IDX_W'(directed_rows[i].slab_field),
                    directed_rows[i].data_field);
        end
        ROW_ALLOC: begin
          submit(KIND_ALLOC, 0, 0, directed_rows[i].typed, directed_rows[i].known);
        end
        default: begin
          submit(KIND_FREE, directed_rows[i].slab_field, directed_rows[i].data_field,
                 directed_rows[i].typed, directed_rows[i].known);
        end
      endcase
    end

    // Largest slabs, eager release, no idling. Halfway through the sender
    // pauses until every result is back.
    write_reg(soa_pkg::REG_OBJECTS_PER_SLAB, 64);
    write_reg(soa_pkg::REG_FREE_LIMIT, 0);
    random_phase(80, 55, 0);
    drain();
    random_phase(80, 55, 0);

    // Two-object slabs under allocate pressure run out of slab slots.
    write_reg(soa_pkg::REG_OBJECTS_PER_SLAB, 2);
    write_reg(soa_pkg::REG_FREE_LIMIT, 0);
    random_phase(160, 80, 57);

    // Slabs are kept while few objects are free; the receiver stalls.
    write_reg(soa_pkg::REG_FREE_LIMIT, 2047);
    recv_stall_pct = 57;
    random_phase(160, 60, 0);

    // An oversized slab size is clamped. The receiver holds off for a long
    // stretch first, so the block backs up and stops taking requests.
    write_reg(soa_pkg::REG_OBJECTS_PER_SLAB, 127);
    write_reg(soa_pkg::REG_FREE_LIMIT, 20);
    recv_stall_pct = 31;
    hold_cycles = HOLD_STRETCH;
    random_phase(160, 55, 31);

    // An undersized slab size is clamped from below.
    write_reg(soa_pkg::REG_OBJECTS_PER_SLAB, 0);
    write_reg(soa_pkg::REG_FREE_LIMIT, 1024);
    recv_stall_pct = 0;
    random_phase(160, 50, 0);

    write_reg(soa_pkg::REG_OBJECTS_PER_SLAB, 7);
    write_reg(soa_pkg::REG_FREE_LIMIT, 5);
    recv_stall_pct = 31;
    random_phase(160, 50, 31);

    recv_stall_pct = 0;
    drain();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/soa_pkg.sv
src/soa_ctrl.sv
src/soa_datapath.sv
src/slab_object_allocator_top.sv
dv/slab_object_allocator_top_tb.sv
